// File: rtl/cabe_pkg.sv
package cabe_pkg;

  localparam int unsigned MAX_SLAVES = 8;
  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned IN_W       = 17;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned SLV_W      = 4;
  localparam int unsigned IDX_W      = $clog2(MAX_SLAVES);
  localparam int unsigned ROW_W      = 4;

  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;

  localparam logic [APB_AW-1:0] ADDR_SLAVE_COUNT = APB_AW'(0);
  localparam logic [SLV_W-1:0]  SLAVE_COUNT_RST  = SLV_W'(1);

  typedef logic [POS_BITS-1:0] pos_t;

  // One closed block waiting to be sent out as range rows
  typedef struct packed {
    pos_t                        start_master;
    pos_t                        end_master;
    pos_t                        len;
    logic [SLV_W-1:0]            slaves;
    logic [MAX_SLAVES-1:0][POS_BITS-1:0] start_slave;
  } blk_t;

endpackage

// File: rtl/cabe_in_if.sv
interface cabe_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [cabe_pkg::IN_W-1:0]  slave_pos_0;
  logic signed [cabe_pkg::IN_W-1:0]  slave_pos_1;
  logic signed [cabe_pkg::IN_W-1:0]  slave_pos_2;
  logic signed [cabe_pkg::IN_W-1:0]  slave_pos_3;
  logic signed [cabe_pkg::IN_W-1:0]  slave_pos_4;
  logic signed [cabe_pkg::IN_W-1:0]  slave_pos_5;
  logic signed [cabe_pkg::IN_W-1:0]  slave_pos_6;
  logic signed [cabe_pkg::IN_W-1:0]  slave_pos_7;
  logic                              last_residue;

  modport source (
    output valid, slave_pos_0, slave_pos_1, slave_pos_2, slave_pos_3,
           slave_pos_4, slave_pos_5, slave_pos_6, slave_pos_7, last_residue,
    input  ready
  );

  modport sink (
    input  valid, slave_pos_0, slave_pos_1, slave_pos_2, slave_pos_3,
           slave_pos_4, slave_pos_5, slave_pos_6, slave_pos_7, last_residue,
    output ready
  );
endinterface

// File: rtl/cabe_out_if.sv
interface cabe_out_if;
  logic                         valid;
  logic                         ready;
  logic [cabe_pkg::ROW_W-1:0]   row_number;
  logic [cabe_pkg::OUT_W-1:0]   range_from;
  logic [cabe_pkg::OUT_W-1:0]   range_to;
  logic                         block_done;

  modport source (
    output valid, row_number, range_from, range_to, block_done,
    input  ready
  );

  modport sink (
    input  valid, row_number, range_from, range_to, block_done,
    output ready
  );
endinterface

// File: rtl/common_aligned_block_extractor_unit.sv
// Path: an item that closes a block puts its first row on row_o through the block queue,
// then the output register; rows follow one per cycle while row_o is ready.
// Throughput: one item per cycle while no block closes. An item that closes blocks holds
// the input until all its rows (1 + slave count per block, up to 18 rows) have left the queue.
// Reset: asynchronous, active low; no open block, master counter 0, slave_count 1,
// queue and output register empty.
module common_aligned_block_extractor_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cabe_in_if.sink                       item_i,
  cabe_out_if.source                    row_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cabe_pkg::APB_AW-1:0]   paddr,
  input  logic [cabe_pkg::APB_DW-1:0]   pwdata,
  output logic [cabe_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  // configuration
  logic [cabe_pkg::SLV_W-1:0] sc_q;
  logic                       cfg_wr;

  // run state
  logic                                 run_open_q, run_open_d;
  cabe_pkg::pos_t                       mc_q, mc_d;
  cabe_pkg::pos_t                       rsm_q, rsm_d;
  cabe_pkg::pos_t                       rss_q [cabe_pkg::MAX_SLAVES];
  logic [cabe_pkg::SLV_W-1:0]           rs_q, rs_d;

  // block queue
  cabe_pkg::blk_t                       blk_q [2];
  logic [1:0]                           pend_q;
  logic [cabe_pkg::ROW_W-1:0]           row_q;

  // output register
  logic                                 ov_q;
  logic [cabe_pkg::ROW_W-1:0]           orow_q, orow_d;
  logic [cabe_pkg::OUT_W-1:0]           ofrom_q, ofrom_d;
  logic [cabe_pkg::OUT_W-1:0]           oto_q, oto_d;
  logic                                 odone_q, odone_d;

  logic                                 in_acc;
  logic                                 load;
  logic                                 row_last;

  logic signed [cabe_pkg::IN_W-1:0]     spos [cabe_pkg::MAX_SLAVES];
  logic [cabe_pkg::MAX_SLAVES-1:0]      aligned;
  cabe_pkg::pos_t                       p [cabe_pkg::MAX_SLAVES];
  logic [cabe_pkg::SLV_W-1:0]           cnt;
  logic                                 ok, all_al, close_a, close_b, keep, opens;
  cabe_pkg::pos_t                       dm;
  cabe_pkg::blk_t                       blk_a, blk_b;
  logic [cabe_pkg::IDX_W-1:0]           sidx;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr == cabe_pkg::ADDR_SLAVE_COUNT);

  always_comb begin
    if (paddr == cabe_pkg::ADDR_SLAVE_COUNT) begin
      prdata = {{(cabe_pkg::APB_DW-cabe_pkg::SLV_W){1'b0}}, sc_q};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= cabe_pkg::SLAVE_COUNT_RST;
    end else if (cfg_wr) begin
      sc_q <= pwdata[cabe_pkg::SLV_W-1:0];
    end
  end

  // ---------------- item evaluation ----------------
  assign item_i.ready = (pend_q == 2'd0);
  assign in_acc       = item_i.valid && item_i.ready;

  always_comb begin
    spos[0] = item_i.slave_pos_0;
    spos[1] = item_i.slave_pos_1;
    spos[2] = item_i.slave_pos_2;
    spos[3] = item_i.slave_pos_3;
    spos[4] = item_i.slave_pos_4;
    spos[5] = item_i.slave_pos_5;
    spos[6] = item_i.slave_pos_6;
    spos[7] = item_i.slave_pos_7;
  end

  // any negative position counts as unaligned; unaligned slots record zero
  always_comb begin
    for (int k = 0; k < cabe_pkg::MAX_SLAVES; k++) begin
      aligned[k] = !spos[k][cabe_pkg::IN_W-1];
      p[k]       = aligned[k] ? spos[k][cabe_pkg::POS_BITS-1:0] : '0;
    end
  end

  assign cnt = (sc_q > cabe_pkg::SLV_W'(cabe_pkg::MAX_SLAVES))
               ? cabe_pkg::SLV_W'(cabe_pkg::MAX_SLAVES) : sc_q;
  assign dm  = mc_q - rsm_q;

  always_comb begin
    ok     = 1'b1;
    all_al = 1'b1;
    for (int k = 0; k < cabe_pkg::MAX_SLAVES; k++) begin
      if (cabe_pkg::SLV_W'(k) < rs_q) begin
        if (!aligned[k] || ((p[k] - cabe_pkg::pos_t'(rss_q[k])) != dm)) begin
          ok = 1'b0;
        end
      end
      if (cabe_pkg::SLV_W'(k) < cnt && !aligned[k]) begin
        all_al = 1'b0;
      end
    end
  end

  assign close_a = run_open_q && !ok;
  assign keep    = run_open_q && ok;
  assign opens   = !keep && all_al;
  assign close_b = item_i.last_residue && (keep || opens);

  always_comb begin
    blk_a.start_master = rsm_q;
    blk_a.end_master   = mc_q - cabe_pkg::pos_t'(1);
    blk_a.len          = mc_q - cabe_pkg::pos_t'(1) - rsm_q;
    blk_a.slaves       = rs_q;
    for (int k = 0; k < cabe_pkg::MAX_SLAVES; k++) begin
      blk_a.start_slave[k] = rss_q[k];
    end

    // block closed by the last residue: either the kept run or a fresh one
    blk_b.start_master = opens ? mc_q : rsm_q;
    blk_b.end_master   = mc_q;
    blk_b.len          = opens ? '0 : dm;
    blk_b.slaves       = opens ? cnt : rs_q;
    for (int k = 0; k < cabe_pkg::MAX_SLAVES; k++) begin
      blk_b.start_slave[k] = opens ? p[k] : rss_q[k];
    end
  end

  always_comb begin
    run_open_d = run_open_q;
    mc_d       = mc_q;
    rsm_d      = rsm_q;
    rs_d       = rs_q;
    if (in_acc) begin
      if (opens) begin
        rsm_d = mc_q;
        rs_d  = cnt;
      end
      if (item_i.last_residue) begin
        run_open_d = 1'b0;
        mc_d       = '0;
      end else begin
        run_open_d = keep || opens;
        mc_d       = mc_q + cabe_pkg::pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      mc_q       <= '0;
      rsm_q      <= '0;
      rs_q       <= '0;
    end else begin
      run_open_q <= run_open_d;
      mc_q       <= mc_d;
      rsm_q      <= rsm_d;
      rs_q       <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && opens) begin
      for (int k = 0; k < cabe_pkg::MAX_SLAVES; k++) begin
        rss_q[k] <= p[k];
      end
    end
  end

  // ---------------- block queue and row drain ----------------
  assign load     = (pend_q != 2'd0) && (!ov_q || row_o.ready);
  assign row_last = (row_q == blk_q[0].slaves);
  assign sidx     = cabe_pkg::IDX_W'(row_q - cabe_pkg::ROW_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      row_q  <= '0;
    end else if (in_acc) begin
      pend_q <= 2'(close_a) + 2'(close_b);
      row_q  <= '0;
    end else if (load) begin
      if (row_last) begin
        pend_q <= pend_q - 2'd1;
        row_q  <= '0;
      end else begin
        row_q  <= row_q + cabe_pkg::ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_q[0] <= close_a ? blk_a : blk_b;
      blk_q[1] <= blk_b;
    end else if (load && row_last) begin
      blk_q[0] <= blk_q[1];
    end
  end

  always_comb begin
    orow_d = row_q;
    if (row_q == '0) begin
      ofrom_d = cabe_pkg::OUT_W'(blk_q[0].start_master);
      oto_d   = cabe_pkg::OUT_W'(blk_q[0].end_master);
      odone_d = (blk_q[0].slaves == '0);
    end else begin
      ofrom_d = cabe_pkg::OUT_W'(blk_q[0].start_slave[sidx]);
      oto_d   = cabe_pkg::OUT_W'(cabe_pkg::pos_t'(blk_q[0].start_slave[sidx])
                                 + blk_q[0].len);
      odone_d = row_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (load) begin
      ov_q <= 1'b1;
    end else if (row_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      orow_q  <= orow_d;
      ofrom_q <= ofrom_d;
      oto_q   <= oto_d;
      odone_q <= odone_d;
    end
  end

  assign row_o.valid      = ov_q;
  assign row_o.row_number = orow_q;
  assign row_o.range_from = ofrom_q;
  assign row_o.range_to   = oto_q;
  assign row_o.block_done = odone_q;

  // ---------------- assertions ----------------
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && item_i.last_residue |=> !run_open_q && (mc_q == '0))
    else $error("last item left a run open or counter nonzero");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !item_i.last_residue |=> mc_q == $past(mc_q) + cabe_pkg::pos_t'(1))
    else $error("master counter did not advance");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_o.valid |-> row_o.row_number <= cabe_pkg::ROW_W'(cabe_pkg::MAX_SLAVES))
    else $error("row number out of range");

  a_idle_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> row_q == '0)
    else $error("row index not reset with empty queue");

  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && row_last && pend_q == 2'd1 |=> row_o.valid && row_o.block_done)
    else $error("last row of queue not flagged done");

endmodule

// File: sim/common_aligned_block_extractor_unit_tb.sv
module common_aligned_block_extractor_unit_tb;
  import cabe_pkg::*;

  localparam int ITEM_TARGET  = 430;
  localparam int N_DIRECTED   = 23;
  localparam int SETTLE       = 4;
  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 60;

  localparam logic [IN_W-1:0]  UNAL       = '1;            // -1
  localparam logic [IN_W-1:0]  NEG_ODD    = 17'h10005;     // negative but not -1
  localparam logic [ROW_W-1:0] MASTER_ROW = '0;

  typedef struct packed {
    logic [MAX_SLAVES-1:0][IN_W-1:0] pos;
    logic                            last;
  } residue_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_number;
    logic [OUT_W-1:0] range_from;
    logic [OUT_W-1:0] range_to;
    logic             block_done;
  } range_row_t;

  // typed expectation of a directed row; EXP_PRED defers to the predictor
  typedef enum logic [1:0] {EXP_NONE, EXP_MASTER, EXP_PAIR, EXP_PRED} exp_kind_e;

  typedef struct packed {
    logic [SLV_W-1:0] cfg;
    logic [IN_W-1:0]  p0;
    logic [IN_W-1:0]  p1;
    logic [IN_W-1:0]  prest;
    logic             last;
    exp_kind_e        exp_kind;
    logic [OUT_W-1:0] m_from;
    logic [OUT_W-1:0] m_to;
    logic [OUT_W-1:0] s_from;
    logic [OUT_W-1:0] s_to;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  cabe_in_if  in_bus ();
  cabe_out_if out_bus ();

  common_aligned_block_extractor_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (in_bus),
    .row_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [SLV_W-1:0] slave_cnt_cfg;
  logic             blk_open;
  pos_t             master_ctr;
  pos_t             blk_start_m;
  pos_t             blk_start_s [MAX_SLAVES];
  logic [SLV_W-1:0] blk_slaves;

  range_row_t range_rows_due [$];
  pos_t       gen_off [MAX_SLAVES];

  bit idle_en;
  bit stall_en;
  bit hold_req;
  int n_err;
  int rows_seen;
  int n_items;
  int n_cfg;
  int quiet_cycles;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{4'd1, 17'd100,   UNAL, UNAL, 1'b0, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd1, 17'd101,   UNAL, UNAL, 1'b0, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd1, UNAL,      UNAL, UNAL, 1'b0, EXP_PAIR,   16'd0, 16'd1, 16'd100, 16'd101},
    '{4'd1, NEG_ODD,   UNAL, UNAL, 1'b0, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd1, 17'd65535, UNAL, UNAL, 1'b0, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    // slave position wraps past 65535 and the run still holds
    '{4'd1, 17'd0,     UNAL, UNAL, 1'b0, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd1, 17'd1,     UNAL, UNAL, 1'b1, EXP_PAIR,   16'd4, 16'd6, 16'd65535, 16'd1},
    '{4'd1, 17'd5,     UNAL, UNAL, 1'b1, EXP_PAIR,   16'd0, 16'd0, 16'd5, 16'd5},
    '{4'd1, UNAL,      UNAL, UNAL, 1'b1, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd1, 17'd0,     UNAL, UNAL, 1'b0, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd1, 17'd5,     UNAL, UNAL, 1'b0, EXP_PAIR,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd1, 17'd6,     UNAL, UNAL, 1'b1, EXP_PAIR,   16'd1, 16'd2, 16'd5, 16'd6},
    '{4'd1, 17'd10,    UNAL, UNAL, 1'b0, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    // offset break plus last: two blocks closed by one item
    '{4'd1, 17'd20,    UNAL, UNAL, 1'b1, EXP_PRED,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd0, UNAL,      UNAL, UNAL, 1'b0, EXP_NONE,   16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd0, UNAL,      UNAL, UNAL, 1'b1, EXP_MASTER, 16'd0, 16'd1, 16'd0, 16'd0},
    '{4'd15, 17'd1000, 17'd1000, 17'd1000, 1'b0, EXP_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd15, 17'd1001, 17'd1001, 17'd1001, 1'b0, EXP_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd15, 17'd1002, 17'd1002, UNAL, 1'b0, EXP_PRED, 16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd15, 17'd0,    17'd0,    17'd0, 1'b0, EXP_NONE, 16'd0, 16'd0, 16'd0, 16'd0},
    // count lowered while a block is open: the open block keeps 8 slaves
    '{4'd2, 17'd1,     17'd1,    UNAL, 1'b0, EXP_PRED, 16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd2, 17'd2,     17'd2,    UNAL, 1'b1, EXP_PRED, 16'd0, 16'd0, 16'd0, 16'd0},
    '{4'd8, 17'd65535, 17'd65535, 17'd65535, 1'b1, EXP_PRED,
      16'd0, 16'd0, 16'd0, 16'd0}
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void enqueue_row(input range_row_t r);
    range_rows_due = {range_rows_due, r};
  endfunction

  function automatic void close_block(input pos_t end_m, input bit keep);
    pos_t       len;
    range_row_t r;
    int         k;
    len = end_m - blk_start_m;
    r.row_number = MASTER_ROW;
    r.range_from = blk_start_m;
    r.range_to   = end_m;
    r.block_done = (blk_slaves == '0);
    if (keep) enqueue_row(r);
    for (k = 0; k < MAX_SLAVES; k++) begin
      if (k < blk_slaves) begin
        r.row_number = ROW_W'(k + 1);
        r.range_from = blk_start_s[k];
        r.range_to   = pos_t'(blk_start_s[k] + len);
        r.block_done = (k + 1 == blk_slaves);
        if (keep) enqueue_row(r);
      end
    end
    blk_open = 1'b0;
  endfunction

  function automatic void predict_range_rows(input residue_t res, input bit keep);
    logic [MAX_SLAVES-1:0] aligned;
    pos_t                  p [MAX_SLAVES];
    pos_t                  m;
    pos_t                  dm;
    logic [SLV_W-1:0]      cnt;
    bit                    ok;
    int                    k;
    m = master_ctr;
    for (k = 0; k < MAX_SLAVES; k++) begin
      aligned[k] = ~res.pos[k][IN_W-1];
      p[k]       = aligned[k] ? res.pos[k][POS_BITS-1:0] : '0;
    end
    if (blk_open) begin
      ok = 1'b1;
      dm = m - blk_start_m;
      for (k = 0; k < MAX_SLAVES; k++)
        if (k < blk_slaves && (!aligned[k] || pos_t'(p[k] - blk_start_s[k]) != dm))
          ok = 1'b0;
      if (!ok) close_block(m - 1'b1, keep);
    end
    if (!blk_open) begin
      cnt = (slave_cnt_cfg > SLV_W'(MAX_SLAVES)) ? SLV_W'(MAX_SLAVES) : slave_cnt_cfg;
      ok  = 1'b1;
      for (k = 0; k < MAX_SLAVES; k++)
        if (k < cnt && !aligned[k]) ok = 1'b0;
      if (ok) begin
        blk_open    = 1'b1;
        blk_start_m = m;
        blk_slaves  = cnt;
        for (k = 0; k < MAX_SLAVES; k++) blk_start_s[k] = p[k];
      end
    end
    if (res.last) begin
      if (blk_open) close_block(m, keep);
      master_ctr = '0;
    end else begin
      master_ctr = m + 1'b1;
    end
  endfunction

  // mostly runs that hold their offsets, with breaks and noise mixed in
  function automatic residue_t next_random_residue(input bit all_new);
    residue_t res;
    int       sel;
    int       k;
    int       hi;
    sel = all_new ? 65 : $urandom_range(0, 99);
    if (sel >= 60 && sel < 75)
      for (k = 0; k < MAX_SLAVES; k++) gen_off[k] = pos_t'($urandom_range(0, 65535));
    for (k = 0; k < MAX_SLAVES; k++)
      res.pos[k] = {1'b0, pos_t'(master_ctr + gen_off[k])};
    hi = (slave_cnt_cfg == '0) ? 0 :
         (slave_cnt_cfg > SLV_W'(MAX_SLAVES)) ? MAX_SLAVES - 1 : slave_cnt_cfg - 1;
    k = $urandom_range(0, hi);
    if (sel >= 75 && sel < 85) begin
      res.pos[k] = {1'b1, pos_t'($urandom)};
    end else if (sel >= 85 && sel < 90) begin
      gen_off[k] = gen_off[k] + 1'b1;
      res.pos[k] = {1'b0, pos_t'(master_ctr + gen_off[k])};
    end else if (sel >= 90) begin
      for (k = 0; k < MAX_SLAVES; k++)
        res.pos[k] = {($urandom_range(0, 3) == 0), pos_t'($urandom)};
    end
    res.last = ($urandom_range(0, 11) == 0);
    return res;
  endfunction

  task automatic offer_residue(input residue_t res);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.slave_pos_0  <= res.pos[0];
    in_bus.slave_pos_1  <= res.pos[1];
    in_bus.slave_pos_2  <= res.pos[2];
    in_bus.slave_pos_3  <= res.pos[3];
    in_bus.slave_pos_4  <= res.pos[4];
    in_bus.slave_pos_5  <= res.pos[5];
    in_bus.slave_pos_6  <= res.pos[6];
    in_bus.slave_pos_7  <= res.pos[7];
    in_bus.last_residue <= res.last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // only once all rows are out; upper data bits are don't-care
  task automatic set_slave_count(input logic [SLV_W-1:0] cnt);
    in_bus.valid <= 1'b0;
    while (range_rows_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    apb_write(ADDR_SLAVE_COUNT, {(APB_DW - SLV_W)'($urandom), cnt});
    slave_cnt_cfg = cnt;
    n_cfg++;
  endtask

  always @(posedge clk) begin : row_check
    range_row_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      rows_seen++;
      if (range_rows_due.size() == 0) begin
        if (n_err < 10)
          $display("unexpected row: row %0d %0d..%0d done %0b", out_bus.row_number,
                   out_bus.range_from, out_bus.range_to, out_bus.block_done);
        n_err++;
      end else begin
        want = range_rows_due.pop_front();
        if (out_bus.row_number !== want.row_number || out_bus.range_from !== want.range_from ||
            out_bus.range_to !== want.range_to || out_bus.block_done !== want.block_done) begin
          if (n_err < 10)
            $display("row mismatch: exp row %0d %0d..%0d done %0b, got row %0d %0d..%0d done %0b",
                     want.row_number, want.range_from, want.range_to, want.block_done,
                     out_bus.row_number, out_bus.range_from, out_bus.range_to,
                     out_bus.block_done);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("** common_aligned_block_extractor_unit: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_bus.ready <= 1'b1;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    dir_row_t         d;
    residue_t         res;
    logic [SLV_W-1:0] cnt;
    bit               squeeze;
    int               phase;
    int               len;
    int               i;
    int               k;

    clk                 = 1'b0;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_bus.valid        = 1'b0;
    in_bus.slave_pos_0  = '0;
    in_bus.slave_pos_1  = '0;
    in_bus.slave_pos_2  = '0;
    in_bus.slave_pos_3  = '0;
    in_bus.slave_pos_4  = '0;
    in_bus.slave_pos_5  = '0;
    in_bus.slave_pos_6  = '0;
    in_bus.slave_pos_7  = '0;
    in_bus.last_residue = 1'b0;
    slave_cnt_cfg       = SLAVE_COUNT_RST;
    blk_open            = 1'b0;
    master_ctr          = '0;
    blk_start_m         = '0;
    blk_slaves          = '0;
    for (k = 0; k < MAX_SLAVES; k++) begin
      blk_start_s[k] = '0;
      gen_off[k]     = pos_t'($urandom);
    end
    idle_en      = 1'b1;
    stall_en     = 1'b1;
    hold_req     = 1'b0;
    n_err        = 0;
    rows_seen    = 0;
    n_items      = 0;
    n_cfg        = 0;
    quiet_cycles = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      d = directed_rows[i];
      if (d.cfg != slave_cnt_cfg) set_slave_count(d.cfg);
      res.last   = d.last;
      res.pos[0] = d.p0;
      res.pos[1] = d.p1;
      for (k = 2; k < MAX_SLAVES; k++) res.pos[k] = d.prest;
      offer_residue(res);
      predict_range_rows(res, d.exp_kind == EXP_PRED);
      case (d.exp_kind)
        EXP_MASTER:
          enqueue_row(range_row_t'{MASTER_ROW, d.m_from, d.m_to, 1'b1});
        EXP_PAIR: begin
          enqueue_row(range_row_t'{MASTER_ROW, d.m_from, d.m_to, 1'b0});
          enqueue_row(range_row_t'{MASTER_ROW + 1'b1, d.s_from, d.s_to, 1'b1});
        end
        default: ;
      endcase
      n_items++;
    end

    // a short run across three slaves, closed by the last residue
    set_slave_count(4'd3);
    for (i = 0; i < 6; i++) begin
      for (k = 0; k < MAX_SLAVES; k++)
        res.pos[k] = {1'b0, pos_t'(master_ctr + pos_t'(k * 1111 + 7))};
      res.last = (i == 5);
      offer_residue(res);
      predict_range_rows(res, 1'b1);
      n_items++;
    end

    phase = 0;
    while (n_items < ITEM_TARGET) begin
      case (phase)
        0:       cnt = 4'd8;
        1:       cnt = 4'd0;
        2:       cnt = 4'd15;
        3:       cnt = 4'd1;
        default: cnt = SLV_W'($urandom_range(0, 15));
      endcase
      set_slave_count(cnt);
      squeeze = (phase == 2);
      if (squeeze) begin
        hold_req = 1'b1;
        idle_en  = 1'b0;
      end
      len = squeeze ? 30 : $urandom_range(15, 50);
      for (i = 0; i < len && n_items < ITEM_TARGET; i++) begin
        if (!squeeze) begin
          idle_en  = (n_items < ITEM_TARGET - 60);
          stall_en = idle_en;
        end
        res = next_random_residue(squeeze);
        offer_residue(res);
        predict_range_rows(res, 1'b1);
        n_items++;
      end
      phase++;
    end

    in_bus.valid <= 1'b0;
    stall_en = 1'b0;
    while (range_rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d residues over directed cases and %0d random slave count phases",
             n_items, phase);
    $display("run: %0d range rows checked over %0d slave count writes, %0d mismatches",
             rows_seen, n_cfg, n_err);
    if (n_err == 0) begin
      $display("** common_aligned_block_extractor_unit: PASSED **");
    end else begin
      $display("** common_aligned_block_extractor_unit: FAILED **");
    end
    $finish;
  end

endmodule
